// ===== rtl/m5f_pkg.sv =====
`timescale 1ns / 1ps

package m5f_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TAPS             = 5;
    localparam int HIST_DEPTH       = TAPS - 1;
    localparam int HIST_IDX_W       = $clog2(HIST_DEPTH);
    localparam int SEEN_W           = $clog2(HIST_DEPTH + 1);
    localparam int CENTER           = TAPS / 2;
    localparam int RANK_W           = $clog2(TAPS);
    localparam int REM_W            = $clog2(CENTER + 2);

endpackage

// ===== rtl/m5f_in_if.sv =====
`timescale 1ns / 1ps

interface m5f_in_if
    import m5f_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== rtl/m5f_out_if.sv =====
`timescale 1ns / 1ps

interface m5f_out_if
    import m5f_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] median;
    logic                           final_res;

    modport source (output valid, output median, output final_res, input ready);
    modport sink   (input valid, input median, input final_res, output ready);
endinterface

// ===== rtl/median5_filter_edge_replicate_top.sv =====
`timescale 1ns / 1ps

// Streaming five-tap median filter with edge replication. One sample is taken per clock
// unless stalled. A sample completing a window goes into the window register and its median
// into the output register once free, so a sample may still be taken while a result waits.
// The first two samples of a stream give no result unless one is flagged last. The sample
// flagged last releases up to three medians (the final one flagged), which leave one per
// clock through the single output register when not stalled; that sample holds the input
// until the last median moves on. Samples before the start read as the first sample, past
// the end as the last. Samples are only compared, so the binary point is wherever the user puts it.

module median5_filter_edge_replicate_top
    import m5f_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    m5f_in_if.sink     i_in,
    m5f_out_if.source  o_out
);

    logic signed [SAMPLE_WIDTH-1:0]        r_hist [HIST_DEPTH];
    logic [SEEN_W-1:0]                     r_seen;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0]     r_win;
    logic [REM_W-1:0]                      r_rem;
    logic                                  r_last;
    logic [SAMPLE_WIDTH-1:0]               r_med;
    logic                                  r_fin;
    logic                                  r_oval;

    logic [TAPS-1:0][SAMPLE_WIDTH-1:0]     bk;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0]     n_win;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0]     win_shift;
    logic [REM_W-1:0]                      n_rem;
    logic [SEEN_W-1:0]                     seen_m1;
    logic [1:0]                            start_m;
    logic [SAMPLE_WIDTH-1:0]               med;
    logic                                  out_free;
    logic                                  adv;
    logic                                  in_ready;
    logic                                  acc;

    assign out_free = !r_oval || o_out.ready;
    assign adv      = (r_rem != '0) && out_free;
    assign in_ready = (r_rem == '0) || ((r_rem == REM_W'(1)) && out_free);
    assign acc      = i_in.valid && in_ready;
    assign seen_m1  = r_seen - 1'b1;

    // samples d back from the current one, clamped to the stream start
    always_comb begin
        bk[0] = i_in.sample;
        for (int d = 1; d < TAPS; d++) begin
            if (SEEN_W'(d) <= r_seen) begin
                bk[d] = r_hist[d-1];
            end else if (r_seen != '0) begin
                bk[d] = r_hist[seen_m1[HIST_IDX_W-1:0]];
            end else begin
                bk[d] = i_in.sample;
            end
        end
    end

    // first window of this request; taps past the current sample read the current one
    always_comb begin
        if (!i_in.last || (r_seen >= SEEN_W'(CENTER))) begin
            start_m = 2'(CENTER);
        end else begin
            start_m = r_seen[1:0];
        end

        for (int k = 0; k < TAPS; k++) begin
            if ((int'(start_m) + CENTER - k) <= 0) begin
                n_win[k] = i_in.sample;
            end else begin
                n_win[k] = bk[int'(start_m) + CENTER - k];
            end
        end

        if (!i_in.last) begin
            n_rem = (r_seen >= SEEN_W'(CENTER)) ? REM_W'(1) : '0;
        end else begin
            n_rem = REM_W'(start_m) + REM_W'(1);
        end
    end

    // advance the window by one centre position, replicating the newest sample
    always_comb begin
        for (int k = 0; k < TAPS - 1; k++) begin
            win_shift[k] = r_win[k+1];
        end
        win_shift[TAPS-1] = r_win[TAPS-1];
    end

    m5f_median5 #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_median (
        .i_win (r_win),
        .o_med (med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (acc) begin
            if (i_in.last) begin
                r_seen <= '0;
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    r_hist[i] <= '0;
                end
            end else begin
                for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= i_in.sample;
                if (r_seen < SEEN_W'(HIST_DEPTH)) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (acc) begin
            r_rem <= n_rem;
        end else if (adv) begin
            r_rem <= r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_win  <= n_win;
            r_last <= i_in.last;
        end else if (adv) begin
            r_win  <= win_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (adv) begin
            r_oval <= 1'b1;
        end else if (o_out.ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_med <= med;
            r_fin <= r_last && (r_rem == REM_W'(1));
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_oval;
    assign o_out.median    = r_med;
    assign o_out.final_res = r_fin;

endmodule

// ===== rtl/m5f_median5.sv =====
`timescale 1ns / 1ps

module m5f_median5
    import m5f_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic [TAPS-1:0][SAMPLE_WIDTH-1:0] i_win,
    output logic [SAMPLE_WIDTH-1:0]           o_med
);

    logic [TAPS-1:0][RANK_W-1:0] rank;
    logic [TAPS-1:0]             pick;

    // rank each tap; ties broken by position so exactly one tap lands in the middle
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < TAPS; j++) begin
                if (j != i) begin
                    if (($signed(i_win[j]) < $signed(i_win[i])) ||
                        ((i_win[j] == i_win[i]) && (j < i))) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
            pick[i] = (rank[i] == RANK_W'(CENTER));
        end
    end

    always_comb begin
        o_med = '0;
        for (int i = 0; i < TAPS; i++) begin
            o_med = o_med | (i_win[i] & {SAMPLE_WIDTH{pick[i]}});
        end
    end

endmodule

// ===== rtl/m5f_checker.sv =====
`timescale 1ns / 1ps

module m5f_checker
    import m5f_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] i_out_median,
    input logic                    i_out_final_res
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_median) && $stable(i_out_final_res))
        else $error("stalled output request changed");

    a_stall_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !i_in_ready |=> i_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind median5_filter_edge_replicate_top m5f_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_m5f_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_median    (o_out.median),
    .i_out_final_res (o_out.final_res)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import m5f_pkg::*;

    localparam int SW         = SAMPLE_WIDTH_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 10;
    localparam int RAND_ITEMS = 160;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last;
        bit                   hold;
        int unsigned          phase;
    } t_sample_req;

    typedef struct {
        logic signed [SW-1:0] median;
        logic                 final_res;
    } t_median_res;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    m5f_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
    m5f_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

    median5_filter_edge_replicate_top #(.SAMPLE_WIDTH(SW)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_sample_req sample_q [$];
    t_median_res median_q [$];

    logic signed [SW-1:0] hist [HIST_DEPTH];
    int unsigned          seen_n;

    int unsigned snd_pct [3] = '{30, 59, 0};
    int unsigned rcv_pct [3] = '{59, 30, 0};
    int unsigned snd_idle = 30;
    int unsigned rcv_idle = 59;

    logic        in_took = 1'b0;
    int unsigned idle_cnt = 0;
    int unsigned err_cnt = 0;
    int unsigned n_samples = 0;
    int unsigned n_streams = 0;
    int unsigned n_medians = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // sample d positions behind the current one, replicated at the stream start
    function automatic logic signed [SW-1:0] tap_back(logic signed [SW-1:0] cur, int d);
        if (d <= 0) return cur;
        if (d <= int'(seen_n)) return hist[d-1];
        if (seen_n > 0) return hist[seen_n-1];
        return cur;
    endfunction

    function automatic logic signed [SW-1:0] window_median(logic signed [SW-1:0] cur, int m);
        logic signed [SW-1:0] w [TAPS];
        logic signed [SW-1:0] t;
        for (int i = 0; i < TAPS; i++) w[i] = tap_back(cur, m + 2 - i);
        for (int i = 0; i < TAPS - 1; i++)
            for (int j = 0; j < TAPS - 1 - i; j++)
                if (w[j] > w[j+1]) begin
                    t      = w[j];
                    w[j]   = w[j+1];
                    w[j+1] = t;
                end
        return w[CENTER];
    endfunction

    function automatic void filter_push(logic signed [SW-1:0] cur, logic last);
        t_median_res r;
        if (!last) begin
            if (seen_n >= 2) begin
                r.median    = window_median(cur, 2);
                r.final_res = 1'b0;
                median_q.push_back(r);
            end
            for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = cur;
            if (seen_n < HIST_DEPTH) seen_n++;
        end else begin
            for (int m = 2; m >= 0; m--)
                if (seen_n >= m) begin
                    r.median    = window_median(cur, m);
                    r.final_res = (m == 0);
                    median_q.push_back(r);
                end
            for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
            seen_n = 0;
        end
    endfunction

    task automatic add_sample(logic signed [SW-1:0] s, logic last, int unsigned ph, bit hold);
        t_sample_req req;
        req.sample = s;
        req.last   = last;
        req.hold   = hold;
        req.phase  = ph;
        sample_q.push_back(req);
    endtask

    // driver: present the next request at the falling edge
    always @(negedge clk) begin
        t_sample_req req;
        if (rst_n && (!in_if.valid || in_took)) begin
            if (sample_q.size() != 0 && !(sample_q[0].hold && median_q.size() != 0)
                    && $urandom_range(99) >= snd_idle) begin
                req = sample_q.pop_front();
                in_if.sample <= req.sample;
                in_if.last   <= req.last;
                in_if.valid  <= 1'b1;
                snd_idle = snd_pct[req.phase];
                rcv_idle = rcv_pct[req.phase];
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        out_if.ready <= rst_n && ($urandom_range(99) >= rcv_idle);
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge clk) begin
        t_median_res exp_r;
        logic        in_fire;
        logic        out_fire;
        in_fire  = rst_n && in_if.valid && in_if.ready;
        out_fire = rst_n && out_if.valid && out_if.ready;
        in_took <= in_fire;
        if (in_fire) begin
            filter_push(in_if.sample, in_if.last);
            n_samples++;
            if (in_if.last) n_streams++;
        end
        if (out_fire) begin
            n_medians++;
            if (median_q.size() == 0) begin
                $error("median: unexpected result %0d (final_res %0b)",
                       out_if.median, out_if.final_res);
                err_cnt++;
            end else begin
                exp_r = median_q.pop_front();
                if (out_if.median !== exp_r.median) begin
                    $error("median: expected %0d, got %0d", exp_r.median, out_if.median);
                    err_cnt++;
                end
                if (out_if.final_res !== exp_r.final_res) begin
                    $error("final_res: expected %0b, got %0b",
                           exp_r.final_res, out_if.final_res);
                    err_cnt++;
                end
            end
        end
        if (rst_n) begin
            if (in_fire || out_fire) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("tb: watchdog expired, %0d results outstanding", median_q.size());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int unsigned          n_rand;
        int unsigned          len;
        int unsigned          kind;
        int unsigned          ph;
        int unsigned          prev_ph;
        int                   step;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] base;

        in_if.valid   = 1'b0;
        in_if.sample  = '0;
        in_if.last    = 1'b0;
        out_if.ready  = 1'b0;
        seen_n        = 0;
        for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;

        // single-sample streams at both extremes
        add_sample(SW'(-32768), 1'b1, 0, 1'b0);
        add_sample(SW'(32767), 1'b1, 0, 1'b0);
        // two-, three- and four-sample streams
        add_sample(SW'(32767), 1'b0, 0, 1'b0);
        add_sample(SW'(-32768), 1'b1, 0, 1'b0);
        add_sample(SW'(0), 1'b0, 0, 1'b0);
        add_sample(SW'(-1), 1'b0, 0, 1'b0);
        add_sample(SW'(1), 1'b1, 0, 1'b0);
        add_sample(16'sh5555, 1'b0, 0, 1'b0);
        add_sample(16'shAAAA, 1'b0, 0, 1'b0);
        add_sample(SW'(32767), 1'b0, 0, 1'b0);
        add_sample(SW'(-32768), 1'b1, 0, 1'b0);
        // long enough to saturate the history, with ties
        add_sample(SW'(-32768), 1'b0, 0, 1'b0);
        add_sample(SW'(32767), 1'b0, 0, 1'b0);
        add_sample(SW'(0), 1'b0, 0, 1'b0);
        add_sample(SW'(5), 1'b0, 0, 1'b0);
        add_sample(SW'(5), 1'b0, 0, 1'b0);
        add_sample(SW'(-1), 1'b0, 0, 1'b0);
        add_sample(SW'(100), 1'b1, 0, 1'b0);

        n_rand  = 0;
        prev_ph = 0;
        while (n_rand < RAND_ITEMS) begin
            len  = ($urandom_range(7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            kind = $urandom_range(3);
            ph   = (n_rand < RAND_ITEMS / 3) ? 0 : (n_rand < 2 * RAND_ITEMS / 3) ? 1 : 2;
            base = SW'($urandom);
            step = int'($urandom_range(2000)) - 1000;
            for (int k = 0; k < int'(len); k++) begin
                case (kind)
                    0: v = SW'($urandom);
                    1: v = SW'(int'($urandom_range(8)) - 4);
                    2: v = $urandom_range(1) ? SW'(32767) : SW'(-32768);
                    default: v = SW'(base + k * step);
                endcase
                add_sample(v, k == int'(len) - 1, ph,
                           k == 0 && (ph != prev_ph || $urandom_range(9) == 0));
            end
            prev_ph = ph;
            n_rand += len;
        end

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (sample_q.size() != 0 || in_if.valid) @(posedge clk);
        while (median_q.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("tb: %0d samples in %0d streams, %0d medians checked", n_samples, n_streams,
                 n_medians);
        $display("tb: lengths 1 to 40, random/narrow/extreme/ramp data, three stall profiles");
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
